// ----- sv/world_to_grid_map_lookup_defines.svh -----
// Assertion macros shared by the map lookup RTL.
`ifndef WORLD_TO_GRID_MAP_LOOKUP_DEFINES_SVH
`define WORLD_TO_GRID_MAP_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define WGML_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wgml assertion failed");

// Next-cycle implication, disabled in reset.
`define WGML_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wgml assertion failed");

`endif

// ----- sv/wgml_pkg.sv -----
// Types and constants of the world-to-grid map lookup.
package wgml_pkg;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Config register indexes
  localparam logic [2:0] CFG_ORIGIN_ROW = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_COL = 3'd1;
  localparam logic [2:0] CFG_COS        = 3'd2;
  localparam logic [2:0] CFG_SIN        = 3'd3;
  localparam logic [2:0] CFG_MAP_ROWS   = 3'd4;
  localparam logic [2:0] CFG_MAP_COLS   = 3'd5;

  typedef struct packed {
    logic [10:0] origin_row;
    logic [10:0] origin_col;
    logic [23:0] cos_over_scale;
    logic [23:0] sin_over_scale;
    logic [11:0] map_rows;
    logic [11:0] map_cols;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    origin_row:     11'd1088,
    origin_col:     11'd977,
    cos_over_scale: 24'd1992026,
    sin_over_scale: 24'd155027,
    map_rows:       12'd0,
    map_cols:       12'd0
  };

  // Datapath widths fixed by the field formats
  localparam int PROD_W  = 56;   // Q16.16 x Q8.16 -> Q.32
  localparam int SUM_W   = 57;
  localparam int HI_W    = SUM_W - 32;
  localparam int COORD_W = 27;   // rounded coordinate plus origin
  localparam logic [SUM_W-1:0] HALF_Q32 = 57'h0_0000_8000_0000;

  localparam logic [7:0] GREY_OUTSIDE = 8'hFF;

  // Queue between front and back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = 3;
  localparam int QCNT_W = 4;

  typedef struct packed {
    logic       is_query;
    logic       write_en;
    logic       outside;
    logic [7:0] grey;
  } ctrl_t;

  localparam int CTRL_W = $bits(ctrl_t);

  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  typedef struct packed {
    logic [1:0] inflight;
  } fstat_t;

endpackage

// ----- sv/wgml_front.sv -----
// Front pipeline: takes requests, rotates and scales queries, classifies them.
module wgml_front #(
  parameter int ROW_BITS = 11,
  parameter int COL_BITS = 11,
  parameter int ADDR_W   = ROW_BITS + COL_BITS,
  parameter int DATA_W   = wgml_pkg::CTRL_W + ADDR_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                opcode_i,
  input  logic signed [31:0]  world_x_i,
  input  logic signed [31:0]  world_y_i,
  input  logic [10:0]         load_row_i,
  input  logic [10:0]         load_col_i,
  input  logic [7:0]          load_grey_i,
  input  wgml_pkg::cfg_t      cfg_i,
  output logic                push_o,
  output logic [DATA_W-1:0]   push_data_o,
  output wgml_pkg::fstat_t    stat_o
);

  localparam int PW = wgml_pkg::PROD_W;
  localparam int SW = wgml_pkg::SUM_W;
  localparam int HW = wgml_pkg::HI_W;
  localparam int CW = wgml_pkg::COORD_W;
  localparam logic [CW-1:0] ROW_SPAN = CW'(1 << ROW_BITS);
  localparam logic [CW-1:0] COL_SPAN = CW'(1 << COL_BITS);

  // valid bits
  logic v1_q, v2_q, v3_q;

  // stage 1: products and load fields
  logic signed [PW-1:0] p_xc_q, p_ys_q, p_yc_q, p_xs_q;
  logic                 q1_q, lok1_q;
  logic [ADDR_W-1:0]    la1_q;
  logic [7:0]           lg1_q;
  logic                 lok_d;

  // stage 2: Q.32 sums with the half added
  logic [SW-1:0]        rs2_q, cs2_q;
  logic                 q2_q, lok2_q;
  logic [ADDR_W-1:0]    la2_q;
  logic [7:0]           lg2_q;

  // stage 3: pixel coordinates
  logic [CW-1:0]        row3_q, col3_q;
  logic [CW-1:0]        row_d, col_d;
  logic                 q3_q, lok3_q;
  logic [ADDR_W-1:0]    la3_q;
  logic [7:0]           lg3_q;

  logic [CW-1:0]        rlim, clim;
  logic                 in_map;
  wgml_pkg::ctrl_t      ctrl;
  logic [ADDR_W-1:0]    addr;

  assign lok_d = (32'(load_row_i) < (32'd1 << ROW_BITS)) &&
                 (32'(load_col_i) < (32'd1 << COL_BITS));

  // truncate toward zero: floor, plus one for negative values with a fraction
  always_comb begin
    row_d = CW'($signed(rs2_q[SW-1 -: HW])) + CW'(cfg_i.origin_row)
          + CW'(rs2_q[SW-1] & (|rs2_q[31:0]));
    col_d = CW'($signed(cs2_q[SW-1 -: HW])) + CW'(cfg_i.origin_col)
          + CW'(cs2_q[SW-1] & (|cs2_q[31:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_xc_q <= world_x_i * $signed(cfg_i.cos_over_scale);
    p_ys_q <= world_y_i * $signed(cfg_i.sin_over_scale);
    p_yc_q <= world_y_i * $signed(cfg_i.cos_over_scale);
    p_xs_q <= world_x_i * $signed(cfg_i.sin_over_scale);
    q1_q   <= (opcode_i == wgml_pkg::OP_QUERY);
    lok1_q <= lok_d;
    la1_q  <= {ROW_BITS'(load_row_i), COL_BITS'(load_col_i)};
    lg1_q  <= load_grey_i;

    rs2_q  <= SW'(p_xc_q) + SW'(p_ys_q) + wgml_pkg::HALF_Q32;
    cs2_q  <= SW'(p_yc_q) - SW'(p_xs_q) + wgml_pkg::HALF_Q32;
    q2_q   <= q1_q;
    lok2_q <= lok1_q;
    la2_q  <= la1_q;
    lg2_q  <= lg1_q;

    row3_q <= row_d;
    col3_q <= col_d;
    q3_q   <= q2_q;
    lok3_q <= lok2_q;
    la3_q  <= la2_q;
    lg3_q  <= lg2_q;
  end

  // bounds check against the map size, clipped to the store
  always_comb begin
    rlim   = (CW'(cfg_i.map_rows) > ROW_SPAN) ? ROW_SPAN : CW'(cfg_i.map_rows);
    clim   = (CW'(cfg_i.map_cols) > COL_SPAN) ? COL_SPAN : CW'(cfg_i.map_cols);
    in_map = !row3_q[CW-1] && (row3_q < rlim) && !col3_q[CW-1] && (col3_q < clim);
    ctrl.is_query = q3_q;
    ctrl.write_en = !q3_q && lok3_q;
    ctrl.outside  = q3_q && !in_map;
    ctrl.grey     = lg3_q;
    addr = q3_q ? {row3_q[ROW_BITS-1:0], col3_q[COL_BITS-1:0]} : la3_q;
  end

  assign push_o          = v3_q;
  assign push_data_o     = {ctrl, addr};
  assign stat_o.inflight = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);

endmodule

// ----- sv/wgml_fifo.sv -----
// Short request queue between the front pipeline and the map back end.
`include "world_to_grid_map_lookup_defines.svh"

module wgml_fifo #(
  parameter int DATA_W = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [DATA_W-1:0]  data_i,
  input  logic               pop_i,
  output logic [DATA_W-1:0]  data_o,
  output wgml_pkg::qstat_t   stat_o
);

  localparam int PW = wgml_pkg::QPTR_W;
  localparam int CW = wgml_pkg::QCNT_W;

  logic [DATA_W-1:0] buf_q [wgml_pkg::QDEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o           = buf_q[rd_ptr_q];
  assign stat_o.count     = count_q;
  assign stat_o.not_empty = (count_q != '0);

  `WGML_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, (count_q < CW'(wgml_pkg::QDEPTH)) || pop_i)
  `WGML_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, count_q != '0)
  `WGML_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1)

endmodule

// ----- sv/wgml_back.sv -----
// Back end: map store writes and reads, result register.
`include "world_to_grid_map_lookup_defines.svh"

module wgml_back #(
  parameter int ROW_BITS = 11,
  parameter int COL_BITS = 11,
  parameter int ADDR_W   = ROW_BITS + COL_BITS,
  parameter int DATA_W   = wgml_pkg::CTRL_W + ADDR_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_i,
  input  logic [DATA_W-1:0]  head_i,
  output logic               done_o,
  output logic [7:0]         grey_o,
  output logic               outside_o
);

  logic [7:0]        mem_q [2**ADDR_W];
  logic [7:0]        rd_q;
  logic              done_q, outside_q;
  wgml_pkg::ctrl_t   ctrl;
  logic [ADDR_W-1:0] addr;

  assign ctrl = wgml_pkg::ctrl_t'(head_i[DATA_W-1 -: wgml_pkg::CTRL_W]);
  assign addr = head_i[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (pop_i && ctrl.write_en) begin
      mem_q[addr] <= ctrl.grey;
    end
    rd_q      <= mem_q[addr];
    outside_q <= ctrl.outside;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= pop_i && ctrl.is_query;
    end
  end

  assign done_o    = done_q;
  assign outside_o = outside_q;
  assign grey_o    = outside_q ? wgml_pkg::GREY_OUTSIDE : rd_q;

  `WGML_ASSERT_NEXT(a_query_done, clk_i, rst_ni, pop_i && ctrl.is_query, done_o)
  `WGML_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, !(pop_i && ctrl.is_query), !done_o)
  `WGML_ASSERT_IMPL(a_write_is_load, clk_i, rst_ni, pop_i && ctrl.write_en, !ctrl.is_query && !ctrl.outside)

endmodule

// ----- sv/world_to_grid_map_lookup.sv -----
// Top level of the world-to-grid map lookup.
//
// Request channel: a request is taken at a rising edge with start_i high and
// busy_o low. opcode_i selects a load (write load_grey_i at load_row_i /
// load_col_i) or a query (world point world_x_i, world_y_i in Q16.16).
// Result channel: each query gives one result, shown on grey_o / outside_o
// for exactly one cycle with done_o high; loads give none. The receiver
// cannot hold results off, and none is needed: the back end never stalls.
// Path: the accept edge loads the first of three front stages, then the
// request is pushed into the queue, and the back end registers the map read
// as it raises done_o.
// Throughput: one request per cycle, set by the single map memory port that
// takes one load or one query read per cycle. busy_o only rises when the
// front stages plus the queue hold a full queue's worth of requests.
// Config: cfg_we_i writes cfg_data_i to register cfg_index_i (0..5); other
// indexes are dropped. Write only while no request is in flight; unchecked.
// Reset: config returns to its defaults and the pipeline and queue empty;
// map contents are undefined until loaded, and no clearing pass is run.
module world_to_grid_map_lookup #(
  parameter int ROW_BITS = 11,
  parameter int COL_BITS = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               opcode_i,
  input  logic signed [31:0] world_x_i,
  input  logic signed [31:0] world_y_i,
  input  logic [10:0]        load_row_i,
  input  logic [10:0]        load_col_i,
  input  logic [7:0]         load_grey_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output logic               done_o,
  output logic [7:0]         grey_o,
  output logic               outside_o
);

  localparam int ADDR_W = ROW_BITS + COL_BITS;
  localparam int DATA_W = wgml_pkg::CTRL_W + ADDR_W;
  localparam int QCW    = wgml_pkg::QCNT_W;

  wgml_pkg::cfg_t   cfg_q, cfg_d;
  wgml_pkg::fstat_t f_stat;
  wgml_pkg::qstat_t q_stat;
  logic              accept;
  logic              push;
  logic [DATA_W-1:0] push_data, head;

  // Config register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        wgml_pkg::CFG_ORIGIN_ROW: cfg_d.origin_row     = cfg_data_i[10:0];
        wgml_pkg::CFG_ORIGIN_COL: cfg_d.origin_col     = cfg_data_i[10:0];
        wgml_pkg::CFG_COS:        cfg_d.cos_over_scale = cfg_data_i;
        wgml_pkg::CFG_SIN:        cfg_d.sin_over_scale = cfg_data_i;
        wgml_pkg::CFG_MAP_ROWS:   cfg_d.map_rows       = cfg_data_i[11:0];
        wgml_pkg::CFG_MAP_COLS:   cfg_d.map_cols       = cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= wgml_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Hold off new requests while the queue could not take everything in flight
  assign busy_o = (q_stat.count + QCW'(f_stat.inflight)) >= QCW'(wgml_pkg::QDEPTH);
  assign accept = start_i && !busy_o;

  wgml_front #(
    .ROW_BITS (ROW_BITS),
    .COL_BITS (COL_BITS),
    .ADDR_W   (ADDR_W),
    .DATA_W   (DATA_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .world_x_i   (world_x_i),
    .world_y_i   (world_y_i),
    .load_row_i  (load_row_i),
    .load_col_i  (load_col_i),
    .load_grey_i (load_grey_i),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .push_data_o (push_data),
    .stat_o      (f_stat)
  );

  wgml_fifo #(
    .DATA_W (DATA_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (q_stat.not_empty),
    .data_o (head),
    .stat_o (q_stat)
  );

  // Back end drains one entry every cycle the queue is not empty
  wgml_back #(
    .ROW_BITS (ROW_BITS),
    .COL_BITS (COL_BITS),
    .ADDR_W   (ADDR_W),
    .DATA_W   (DATA_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pop_i     (q_stat.not_empty),
    .head_i    (head),
    .done_o    (done_o),
    .grey_o    (grey_o),
    .outside_o (outside_o)
  );

endmodule
